@@ rtl/core/tmqmb_pkg.sv @@
// tmqmb_pkg: shared constants, codes and types of the tagged multi-queue message buffer
// used by tmqmb_front, tmqmb_queue, tmqmb_back and the top level
// no dependencies
`default_nettype none

package tmqmb_pkg;

    // geometry
    localparam int SLOTS       = 4;
    localparam int RING_DEPTH  = 4;
    localparam int ENTRY_BYTES = 64;
    localparam int HDR_LEN     = 4;
    localparam int N_IDREGS    = 4;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int RING_W  = $clog2(RING_DEPTH);
    localparam int ENT_W   = SLOT_W + RING_W;
    localparam int ENTRIES = SLOTS * RING_DEPTH;
    localparam int POS_W   = $clog2(ENTRY_BYTES);
    localparam int LEN_W   = 7;
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int MEM_AW  = ENT_W + POS_W;

    // field widths
    localparam int ID_W    = 16;
    localparam int MLEN_W  = 16;
    localparam int DATA_W  = 8;
    localparam int LIMIT_W = 16;
    localparam int STS_W   = 3;
    localparam int MODE_W  = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ID0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd4;

    // header bytes, little endian 00 01 00 00
    localparam logic [DATA_W-1:0] HDR_BYTE1 = 8'h01;
    localparam logic [DATA_W-1:0] HDR_FILL  = 8'h00;

    // request types
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_NODATA    = 3'd1;
    localparam logic [STS_W-1:0] STS_TOOLARGE  = 3'd2;
    localparam logic [STS_W-1:0] STS_SMALL     = 3'd3;
    localparam logic [STS_W-1:0] STS_PUSHED    = 3'd4;
    localparam logic [STS_W-1:0] STS_DROPPED   = 3'd5;
    localparam logic [STS_W-1:0] STS_UNMATCHED = 3'd6;
    localparam logic [STS_W-1:0] STS_OVERFLOW  = 3'd7;

    // push modes
    localparam logic [MODE_W-1:0] MODE_STORE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVF       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DROP      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNMATCHED = 2'd3;

    // queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // classified item handed from front to back
    typedef struct packed {
        logic                req_type;
        logic                is_first;
        logic                matched;
        logic [SLOT_W-1:0]   mslot;
        logic                too_big;
        logic [POS_W-1:0]    mlen_lo;
        logic [DATA_W-1:0]   data;
        logic                last;
        logic [SLOT_W-1:0]   slot_select;
        logic [LIMIT_W-1:0]  read_limit;
        logic                unlimited;
    } t_cmd;

    // ring clear request from a slot_enable write
    typedef struct packed {
        logic             valid;
        logic [SLOTS-1:0] mask;
    } t_clr;

    // one result
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic [STS_W-1:0]  status;
        logic [LEN_W-1:0]  entry_length;
        logic [FILL_W-1:0] slot_fill;
        logic [SLOT_W-1:0] matched_slot;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/tmqmb_front.sv @@
// tmqmb_front: configuration registers and item classification
// (message start tracking, reader id match, oversize check); uses tmqmb_pkg
`default_nettype none

module tmqmb_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [tmqmb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [tmqmb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                   i_in_valid,
    input  wire                                   i_q_ready,
    input  wire                                   i_req_type,
    input  wire  [tmqmb_pkg::ID_W-1:0]            i_reader_id,
    input  wire  [tmqmb_pkg::MLEN_W-1:0]          i_msg_length,
    input  wire  [tmqmb_pkg::DATA_W-1:0]          i_data_in,
    input  wire                                   i_last_in,
    input  wire  [tmqmb_pkg::SLOT_W-1:0]          i_slot_select,
    input  wire  [tmqmb_pkg::LIMIT_W-1:0]         i_read_limit,
    input  wire                                   i_unlimited_read,
    output logic                                  o_q_push,
    output tmqmb_pkg::t_cmd                       o_cmd,
    output tmqmb_pkg::t_clr                       o_clr
);

    logic [tmqmb_pkg::ID_W-1:0]  r_rid [tmqmb_pkg::N_IDREGS];
    logic [tmqmb_pkg::SLOTS-1:0] r_enable;
    logic                        r_in_msg;

    logic                        match;
    logic [tmqmb_pkg::SLOT_W-1:0] mslot;

    // lowest enabled slot with an equal id wins
    always_comb begin
        match = 1'b0;
        mslot = '0;
        for (int s = tmqmb_pkg::SLOTS - 1; s >= 0; s--) begin
            if (r_enable[s] && (r_rid[s] == i_reader_id)) begin
                match = 1'b1;
                mslot = tmqmb_pkg::SLOT_W'(s);
            end
        end
    end

    always_comb begin
        o_cmd.req_type    = i_req_type;
        o_cmd.is_first    = !r_in_msg;
        o_cmd.matched     = match;
        o_cmd.mslot       = mslot;
        o_cmd.too_big     = (17'(i_msg_length) + 17'(tmqmb_pkg::HDR_LEN))
                            > 17'(tmqmb_pkg::ENTRY_BYTES);
        o_cmd.mlen_lo     = i_msg_length[tmqmb_pkg::POS_W-1:0];
        o_cmd.data        = i_data_in;
        o_cmd.last        = i_last_in;
        o_cmd.slot_select = i_slot_select;
        o_cmd.read_limit  = i_read_limit;
        o_cmd.unlimited   = i_unlimited_read;
    end

    assign o_q_push = i_in_valid && i_q_ready;

    // old or new enable bit set means the ring is cleared
    assign o_clr.valid = i_cfg_we && (i_cfg_index == tmqmb_pkg::CFG_ENABLE);
    assign o_clr.mask  = i_cfg_data[tmqmb_pkg::SLOTS-1:0] | r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tmqmb_pkg::N_IDREGS; i++) begin
                r_rid[i] <= '0;
            end
            r_enable <= '0;
            r_in_msg <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index < tmqmb_pkg::CFG_ENABLE) begin
                    r_rid[i_cfg_index[tmqmb_pkg::SLOT_W-1:0]] <= i_cfg_data;
                end else if (i_cfg_index == tmqmb_pkg::CFG_ENABLE) begin
                    r_enable <= i_cfg_data[tmqmb_pkg::SLOTS-1:0];
                end
            end
            if (o_q_push && (i_req_type == tmqmb_pkg::REQ_PUSH)) begin
                r_in_msg <= !i_last_in;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tmqmb_queue.sv @@
// tmqmb_queue: two-entry command queue between front and back
// uses tmqmb_pkg
`default_nettype none

module tmqmb_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire tmqmb_pkg::t_cmd  i_cmd,
    output logic                  o_ready,
    input  wire                   i_pop,
    output logic                  o_valid,
    output tmqmb_pkg::t_cmd       o_cmd
);

    tmqmb_pkg::t_cmd                  r_slots [tmqmb_pkg::QDEPTH];
    logic [tmqmb_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tmqmb_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tmqmb_pkg::QCNT_W-1:0]     r_count;

    assign o_ready = (r_count != tmqmb_pkg::QCNT_W'(tmqmb_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tmqmb_back.sv @@
// tmqmb_back: ring state, payload memory and result sequencer
// executes pushes and pops from the queue; uses tmqmb_pkg
`default_nettype none

module tmqmb_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cmd_valid,
    input  wire tmqmb_pkg::t_cmd  i_cmd,
    output logic                  o_cmd_pop,
    input  wire tmqmb_pkg::t_clr  i_clr,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output tmqmb_pkg::t_result    o_out
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    // ring state
    logic [tmqmb_pkg::RING_W-1:0] r_wp   [tmqmb_pkg::SLOTS];
    logic [tmqmb_pkg::RING_W-1:0] r_rp   [tmqmb_pkg::SLOTS];
    logic [tmqmb_pkg::FILL_W-1:0] r_fill [tmqmb_pkg::SLOTS];
    logic [tmqmb_pkg::LEN_W-1:0]  r_elen [tmqmb_pkg::ENTRIES];
    logic                         r_eovf [tmqmb_pkg::ENTRIES];
    logic [tmqmb_pkg::RING_W-1:0] n_wp   [tmqmb_pkg::SLOTS];
    logic [tmqmb_pkg::RING_W-1:0] n_rp   [tmqmb_pkg::SLOTS];
    logic [tmqmb_pkg::FILL_W-1:0] n_fill [tmqmb_pkg::SLOTS];
    logic [tmqmb_pkg::LEN_W-1:0]  n_elen [tmqmb_pkg::ENTRIES];
    logic                         n_eovf [tmqmb_pkg::ENTRIES];

    // message in progress
    logic                          r_push_active, n_push_active;
    logic [tmqmb_pkg::SLOT_W-1:0]  r_push_slot,   n_push_slot;
    logic [tmqmb_pkg::MODE_W-1:0]  r_push_mode,   n_push_mode;
    logic [tmqmb_pkg::POS_W-1:0]   r_push_pos,    n_push_pos;
    logic [tmqmb_pkg::POS_W-1:0]   r_push_limit,  n_push_limit;

    // pop stream
    logic                          r_state, n_state;
    logic [tmqmb_pkg::ENT_W-1:0]   r_sentry, n_sentry;
    logic [tmqmb_pkg::LEN_W-1:0]   r_slen, n_slen;
    logic [tmqmb_pkg::SLOT_W-1:0]  r_sslot, n_sslot;
    logic [tmqmb_pkg::FILL_W-1:0]  r_sfill, n_sfill;
    logic [tmqmb_pkg::LEN_W-1:0]   r_idx, n_idx;
    logic                          r_pend, n_pend;

    // output stage
    logic                          r_out_valid, n_out_valid;
    tmqmb_pkg::t_result            r_out, n_out;

    // payload memory
    logic [tmqmb_pkg::DATA_W-1:0]  mem [2**tmqmb_pkg::MEM_AW];
    logic [tmqmb_pkg::DATA_W-1:0]  r_rd_data;
    logic                          mem_we, mem_re;
    logic [tmqmb_pkg::MEM_AW-1:0]  mem_waddr, mem_raddr;
    logic [tmqmb_pkg::LEN_W-1:0]   rd_off;

    // push decode
    logic                          out_free;
    logic [tmqmb_pkg::MODE_W-1:0]  p_mode;
    logic [tmqmb_pkg::SLOT_W-1:0]  p_slot;
    logic [tmqmb_pkg::POS_W-1:0]   p_pos, p_pos_new, p_limit;
    logic [tmqmb_pkg::ENT_W-1:0]   p_e;
    logic                          p_store, p_take;
    logic [tmqmb_pkg::STS_W-1:0]   p_status;
    logic [tmqmb_pkg::LEN_W-1:0]   p_len;

    // pop decode
    logic [tmqmb_pkg::SLOT_W-1:0]  q_slot;
    logic [tmqmb_pkg::FILL_W-1:0]  q_fill;
    logic [tmqmb_pkg::ENT_W-1:0]   q_e;
    logic [tmqmb_pkg::LEN_W-1:0]   q_len;

    // stream
    logic                          load;
    logic [tmqmb_pkg::DATA_W-1:0]  s_byte;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_cmd.is_first) begin
            p_slot  = i_cmd.matched ? i_cmd.mslot : '0;
            p_pos   = '0;
            p_limit = i_cmd.mlen_lo;
            if (!i_cmd.matched) begin
                p_mode = tmqmb_pkg::MODE_UNMATCHED;
            end else if (r_fill[i_cmd.mslot] >= tmqmb_pkg::FILL_W'(tmqmb_pkg::RING_DEPTH)) begin
                p_mode = tmqmb_pkg::MODE_DROP;
            end else if (i_cmd.too_big) begin
                p_mode = tmqmb_pkg::MODE_OVF;
            end else begin
                p_mode = tmqmb_pkg::MODE_STORE;
            end
        end else begin
            p_slot  = r_push_slot;
            p_pos   = r_push_pos;
            p_limit = r_push_limit;
            p_mode  = r_push_mode;
        end
        p_e       = {p_slot, r_wp[p_slot]};
        p_store   = (p_mode == tmqmb_pkg::MODE_STORE);
        p_take    = p_store && (p_pos < p_limit);
        p_pos_new = p_take ? p_pos + 1'b1 : p_pos;
        p_len     = tmqmb_pkg::LEN_W'(tmqmb_pkg::HDR_LEN) + tmqmb_pkg::LEN_W'(p_pos_new);
        case (p_mode)
            tmqmb_pkg::MODE_STORE: p_status = tmqmb_pkg::STS_PUSHED;
            tmqmb_pkg::MODE_OVF:   p_status = tmqmb_pkg::STS_OVERFLOW;
            tmqmb_pkg::MODE_DROP:  p_status = tmqmb_pkg::STS_DROPPED;
            default:               p_status = tmqmb_pkg::STS_UNMATCHED;
        endcase
    end

    always_comb begin
        q_slot = i_cmd.slot_select;
        q_fill = r_fill[q_slot];
        q_e    = {q_slot, r_rp[q_slot]};
        q_len  = r_elen[q_e];
    end

    // byte leaving the read register: header bytes are constants
    assign load   = (r_state == S_STREAM) && r_pend && out_free;
    assign s_byte = (r_idx > tmqmb_pkg::LEN_W'(tmqmb_pkg::HDR_LEN)) ? r_rd_data :
                    ((r_idx == 7'd2) ? tmqmb_pkg::HDR_BYTE1 : tmqmb_pkg::HDR_FILL);
    assign rd_off    = r_idx - tmqmb_pkg::LEN_W'(tmqmb_pkg::HDR_LEN);
    assign mem_raddr = {r_sentry, rd_off[tmqmb_pkg::POS_W-1:0]};

    always_comb begin
        n_wp          = r_wp;
        n_rp          = r_rp;
        n_fill        = r_fill;
        n_elen        = r_elen;
        n_eovf        = r_eovf;
        n_push_active = r_push_active;
        n_push_slot   = r_push_slot;
        n_push_mode   = r_push_mode;
        n_push_pos    = r_push_pos;
        n_push_limit  = r_push_limit;
        n_state       = r_state;
        n_sentry      = r_sentry;
        n_slen        = r_slen;
        n_sslot       = r_sslot;
        n_sfill       = r_sfill;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        o_cmd_pop     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {p_e, p_pos};
        mem_re        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.req_type == tmqmb_pkg::REQ_PUSH) begin
                        mem_we       = p_take;
                        n_push_slot  = p_slot;
                        n_push_mode  = p_mode;
                        n_push_pos   = p_pos_new;
                        n_push_limit = p_limit;
                        n_push_active = !i_cmd.last;
                        n_out.slot_fill = p_store || (p_mode != tmqmb_pkg::MODE_UNMATCHED) ?
                                          r_fill[p_slot] : '0;
                        if (i_cmd.last && (p_store || (p_mode == tmqmb_pkg::MODE_OVF))) begin
                            n_elen[p_e]     = p_store ? p_len : '0;
                            n_eovf[p_e]     = !p_store;
                            n_wp[p_slot]    = (r_wp[p_slot] == tmqmb_pkg::RING_W'(tmqmb_pkg::RING_DEPTH - 1)) ?
                                              '0 : r_wp[p_slot] + 1'b1;
                            n_fill[p_slot]  = r_fill[p_slot] + 1'b1;
                            n_out.slot_fill = r_fill[p_slot] + 1'b1;
                        end
                        n_out_valid        = 1'b1;
                        n_out.data         = '0;
                        n_out.last         = 1'b1;
                        n_out.status       = p_status;
                        n_out.entry_length = p_store ? p_len : '0;
                        n_out.matched_slot = (p_mode == tmqmb_pkg::MODE_UNMATCHED) ? '0 : p_slot;
                    end else begin
                        n_out.data         = '0;
                        n_out.last         = 1'b1;
                        n_out.matched_slot = q_slot;
                        if (q_fill == '0) begin
                            n_out_valid        = 1'b1;
                            n_out.status       = tmqmb_pkg::STS_NODATA;
                            n_out.entry_length = '0;
                            n_out.slot_fill    = q_fill;
                        end else begin
                            // head entry is consumed whatever the outcome
                            n_rp[q_slot]   = (r_rp[q_slot] == tmqmb_pkg::RING_W'(tmqmb_pkg::RING_DEPTH - 1)) ?
                                             '0 : r_rp[q_slot] + 1'b1;
                            n_fill[q_slot] = q_fill - 1'b1;
                            n_elen[q_e]    = '0;
                            n_eovf[q_e]    = 1'b0;
                            n_out.slot_fill = q_fill - 1'b1;
                            if (r_eovf[q_e]) begin
                                n_out_valid        = 1'b1;
                                n_out.status       = tmqmb_pkg::STS_TOOLARGE;
                                n_out.entry_length = '0;
                            end else if (!i_cmd.unlimited &&
                                         (tmqmb_pkg::LIMIT_W'(q_len) > i_cmd.read_limit)) begin
                                n_out_valid        = 1'b1;
                                n_out.status       = tmqmb_pkg::STS_SMALL;
                                n_out.entry_length = q_len;
                            end else if (q_len == '0) begin
                                n_out_valid        = 1'b1;
                                n_out.status       = tmqmb_pkg::STS_OK;
                                n_out.entry_length = '0;
                            end else begin
                                n_state  = S_STREAM;
                                n_sentry = q_e;
                                n_slen   = q_len;
                                n_sslot  = q_slot;
                                n_sfill  = q_fill - 1'b1;
                                n_idx    = '0;
                                n_pend   = 1'b0;
                            end
                        end
                    end
                end
            end
            S_STREAM: begin
                if (load) begin
                    n_out_valid        = 1'b1;
                    n_out.data         = s_byte;
                    n_out.last         = (r_idx == r_slen);
                    n_out.status       = tmqmb_pkg::STS_OK;
                    n_out.entry_length = r_slen;
                    n_out.slot_fill    = r_sfill;
                    n_out.matched_slot = r_sslot;
                    n_pend             = 1'b0;
                    if (r_idx == r_slen) begin
                        n_state = S_IDLE;
                    end
                end
                // keep one read in flight ahead of the output stage
                if ((r_idx < r_slen) && (!r_pend || load)) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // slot_enable write clears the rings it touches
        if (i_clr.valid) begin
            for (int s = 0; s < tmqmb_pkg::SLOTS; s++) begin
                if (i_clr.mask[s]) begin
                    n_wp[s]   = '0;
                    n_rp[s]   = '0;
                    n_fill[s] = '0;
                end
            end
            for (int e = 0; e < tmqmb_pkg::ENTRIES; e++) begin
                if (i_clr.mask[e / tmqmb_pkg::RING_DEPTH]) begin
                    n_elen[e] = '0;
                    n_eovf[e] = 1'b0;
                end
            end
            if (r_push_active && i_clr.mask[r_push_slot] &&
                (r_push_mode != tmqmb_pkg::MODE_UNMATCHED)) begin
                n_push_mode = tmqmb_pkg::MODE_DROP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_sentry     <= n_sentry;
        r_slen       <= n_slen;
        r_sslot      <= n_sslot;
        r_sfill      <= n_sfill;
        r_push_pos   <= n_push_pos;
        r_push_limit <= n_push_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < tmqmb_pkg::SLOTS; s++) begin
                r_wp[s]   <= '0;
                r_rp[s]   <= '0;
                r_fill[s] <= '0;
            end
            for (int e = 0; e < tmqmb_pkg::ENTRIES; e++) begin
                r_elen[e] <= '0;
                r_eovf[e] <= 1'b0;
            end
            r_push_active <= 1'b0;
            r_push_slot   <= '0;
            r_push_mode   <= tmqmb_pkg::MODE_STORE;
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_wp          <= n_wp;
            r_rp          <= n_rp;
            r_fill        <= n_fill;
            r_elen        <= n_elen;
            r_eovf        <= n_eovf;
            r_push_active <= n_push_active;
            r_push_slot   <= n_push_slot;
            r_push_mode   <= n_push_mode;
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_pend        <= n_pend;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ rtl/core/tagged_multi_queue_message_buffer.sv @@
// tagged_multi_queue_message_buffer: top level of the tagged message ring buffer
// instantiates tmqmb_front, tmqmb_queue and tmqmb_back; uses tmqmb_pkg
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready     | req_type, reader_id, msg_length,
//          |           |                             | data_in, last_in, slot_select,
//          |           |                             | read_limit, unlimited_read
//  out     | output    | o_out_valid / i_out_ready   | data_out, last_out, status,
//          |           |                             | entry_length, slot_fill, matched_slot
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// push: the back end pops the item from the queue and registers its one result in the output register
// pop: the first result passes the queue, the ring state read, the payload read register and
// the output register, then one result per stored byte per cycle while the output stage does not stall
// the two-item queue takes further items while the back end or the output stage stalls
// reset is synchronous and active low; all rings come up empty, no clearing pass
// either side may stall at any time; the output register holds its result until taken
`default_nettype none

module tagged_multi_queue_message_buffer (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration
    input  wire                                   i_cfg_we,
    input  wire  [tmqmb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [tmqmb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire                                   i_req_type,
    input  wire  [tmqmb_pkg::ID_W-1:0]            i_reader_id,
    input  wire  [tmqmb_pkg::MLEN_W-1:0]          i_msg_length,
    input  wire  [tmqmb_pkg::DATA_W-1:0]          i_data_in,
    input  wire                                   i_last_in,
    input  wire  [tmqmb_pkg::SLOT_W-1:0]          i_slot_select,
    input  wire  [tmqmb_pkg::LIMIT_W-1:0]         i_read_limit,
    input  wire                                   i_unlimited_read,
    // result items
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [tmqmb_pkg::DATA_W-1:0]          o_data_out,
    output logic                                  o_last_out,
    output logic [tmqmb_pkg::STS_W-1:0]           o_status,
    output logic [tmqmb_pkg::LEN_W-1:0]           o_entry_length,
    output logic [tmqmb_pkg::FILL_W-1:0]          o_slot_fill,
    output logic [tmqmb_pkg::SLOT_W-1:0]          o_matched_slot
);

    // front to queue
    logic               q_push;
    logic               q_ready;
    tmqmb_pkg::t_cmd    front_cmd;
    tmqmb_pkg::t_clr    clr;

    // queue to back
    logic               q_valid;
    logic               q_pop;
    tmqmb_pkg::t_cmd    back_cmd;

    tmqmb_pkg::t_result res;

    // classification and configuration registers
    tmqmb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_q_ready        (q_ready),
        .i_req_type       (i_req_type),
        .i_reader_id      (i_reader_id),
        .i_msg_length     (i_msg_length),
        .i_data_in        (i_data_in),
        .i_last_in        (i_last_in),
        .i_slot_select    (i_slot_select),
        .i_read_limit     (i_read_limit),
        .i_unlimited_read (i_unlimited_read),
        .o_q_push         (q_push),
        .o_cmd            (front_cmd),
        .o_clr            (clr)
    );

    // decouples acceptance from execution
    tmqmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    // rings, payload memory and the output register
    tmqmb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (q_pop),
        .i_clr       (clr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (res)
    );

    assign o_in_ready     = q_ready;
    assign o_data_out     = res.data;
    assign o_last_out     = res.last;
    assign o_status       = res.status;
    assign o_entry_length = res.entry_length;
    assign o_slot_fill    = res.slot_fill;
    assign o_matched_slot = res.matched_slot;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for the tagged multi-queue message buffer
// holds its own ring model in a small scoreboard class; drives the block with plain tasks
// depends on tmqmb_pkg and tagged_multi_queue_message_buffer
`timescale 1ns / 100ps

import tmqmb_pkg::*;

// one input item as presented on the input channel
typedef struct {
    logic                req_type;
    logic [ID_W-1:0]     reader_id;
    logic [MLEN_W-1:0]   msg_length;
    logic [DATA_W-1:0]   data;
    logic                last;
    logic [SLOT_W-1:0]   slot_select;
    logic [LIMIT_W-1:0]  read_limit;
    logic                unlimited;
} t_ring_req;

typedef logic [ID_W-1:0] t_slot_ids [SLOTS];

class msg_ring_scoreboard;
    logic [ID_W-1:0]   slot_id [N_IDREGS];
    logic [SLOTS-1:0]  slot_en;
    logic [DATA_W-1:0] entry_mem [ENTRIES][ENTRY_BYTES];
    int unsigned       entry_len [ENTRIES];
    bit                entry_ovf [ENTRIES];
    int unsigned       wr_ptr [SLOTS];
    int unsigned       rd_ptr [SLOTS];
    int unsigned       fill [SLOTS];
    bit                msg_open;
    int unsigned       msg_slot;
    logic [MODE_W-1:0] msg_mode;
    int unsigned       msg_pos;
    t_result           expected_results [$];
    int                errors;

    function new();
        foreach (slot_id[k]) slot_id[k] = '0;
        slot_en  = '0;
        msg_mode = MODE_STORE;
    endfunction

    function t_result make_result(logic [DATA_W-1:0] d, logic l, logic [STS_W-1:0] st,
                                  int unsigned len, int unsigned fl, int unsigned sl);
        make_result = '{data: d, last: l, status: st, entry_length: LEN_W'(len),
                        slot_fill: FILL_W'(fl), matched_slot: SLOT_W'(sl)};
    endfunction

    // register write; an enable write empties every ring whose bit is set before or after
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        logic [SLOTS-1:0] touched;
        int               s;
        int               e;
        if (idx < CFG_ID0 + N_IDREGS) begin
            slot_id[idx - CFG_ID0] = value;
        end else if (idx == CFG_ENABLE) begin
            touched = value[SLOTS-1:0] | slot_en;
            for (s = 0; s < SLOTS; s++) begin
                if (touched[s]) begin
                    wr_ptr[s] = 0;
                    rd_ptr[s] = 0;
                    fill[s]   = 0;
                    for (e = 0; e < RING_DEPTH; e++) begin
                        entry_len[s * RING_DEPTH + e] = 0;
                        entry_ovf[s * RING_DEPTH + e] = 0;
                    end
                    // a message being stored into a cleared ring is lost
                    if (msg_open && msg_slot == s && msg_mode != MODE_UNMATCHED)
                        msg_mode = MODE_DROP;
                end
            end
            slot_en = value[SLOTS-1:0];
        end
    endfunction

    // works out the results of one accepted item and queues them
    function void note_request(t_ring_req r);
        int unsigned      s;
        int unsigned      e;
        int unsigned      len;
        int unsigned      i;
        int               k;
        logic [STS_W-1:0] st;
        if (r.req_type == REQ_POP) begin
            s = r.slot_select;
            if (fill[s] == 0) begin
                expected_results.push_back(make_result(8'h00, 1'b1, STS_NODATA, 0, 0, s));
                return;
            end
            e   = s * RING_DEPTH + rd_ptr[s];
            len = (entry_len[e] > ENTRY_BYTES) ? ENTRY_BYTES : entry_len[e];
            rd_ptr[s] = (rd_ptr[s] + 1) % RING_DEPTH;
            fill[s]--;
            if (entry_ovf[e])
                expected_results.push_back(make_result(8'h00, 1'b1, STS_TOOLARGE, 0, fill[s], s));
            else if (!r.unlimited && len > r.read_limit)
                expected_results.push_back(make_result(8'h00, 1'b1, STS_SMALL, len, fill[s], s));
            else if (len == 0)
                expected_results.push_back(make_result(8'h00, 1'b1, STS_OK, 0, fill[s], s));
            else
                for (i = 0; i < len; i++)
                    expected_results.push_back(make_result(entry_mem[e][i], i + 1 == len,
                                                           STS_OK, len, fill[s], s));
            entry_len[e] = 0;
            entry_ovf[e] = 0;
            return;
        end

        // first item of a message picks the slot and the way it is handled
        if (!msg_open) begin
            msg_open = 1'b1;
            msg_pos  = 0;
            msg_mode = MODE_UNMATCHED;
            msg_slot = 0;
            for (k = 0; k < SLOTS; k++) begin
                if (slot_en[k] && slot_id[k] == r.reader_id) begin
                    msg_slot = k;
                    if (fill[k] >= RING_DEPTH)
                        msg_mode = MODE_DROP;
                    else if (r.msg_length + HDR_LEN > ENTRY_BYTES)
                        msg_mode = MODE_OVF;
                    else
                        msg_mode = MODE_STORE;
                    break;
                end
            end
            if (msg_mode == MODE_STORE) begin
                e = msg_slot * RING_DEPTH + wr_ptr[msg_slot];
                entry_mem[e][0] = HDR_FILL;
                entry_mem[e][1] = HDR_BYTE1;
                entry_mem[e][2] = HDR_FILL;
                entry_mem[e][3] = HDR_FILL;
                entry_len[e]    = r.msg_length + HDR_LEN;
                entry_ovf[e]    = 0;
            end
        end

        s   = msg_slot;
        e   = s * RING_DEPTH + wr_ptr[s];
        len = 0;
        if (msg_mode == MODE_STORE) begin
            // bytes past the announced length are ignored
            if (msg_pos + HDR_LEN < entry_len[e]) begin
                entry_mem[e][HDR_LEN + msg_pos] = r.data;
                msg_pos++;
            end
            len = HDR_LEN + msg_pos;
        end
        if (r.last) begin
            if (msg_mode == MODE_STORE || msg_mode == MODE_OVF) begin
                entry_len[e] = (msg_mode == MODE_STORE) ? HDR_LEN + msg_pos : 0;
                entry_ovf[e] = (msg_mode == MODE_OVF);
                wr_ptr[s]    = (wr_ptr[s] + 1) % RING_DEPTH;
                fill[s]++;
            end
            msg_open = 1'b0;
        end
        case (msg_mode)
            MODE_STORE: st = STS_PUSHED;
            MODE_OVF:   st = STS_OVERFLOW;
            MODE_DROP:  st = STS_DROPPED;
            default:    st = STS_UNMATCHED;
        endcase
        if (msg_mode == MODE_UNMATCHED)
            expected_results.push_back(make_result(8'h00, 1'b1, st, 0, 0, 0));
        else
            expected_results.push_back(make_result(8'h00, 1'b1, st, len, fill[s], s));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result with nothing pending: status %0d data_out %0h", got.status, got.data);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("data_out", want.data, got.data);
        compare_field("last_out", want.last, got.last);
        compare_field("status", want.status, got.status);
        compare_field("entry_length", want.entry_length, got.entry_length);
        compare_field("slot_fill", want.slot_fill, got.slot_fill);
        compare_field("matched_slot", want.matched_slot, got.matched_slot);
    endfunction
endclass

module testbench;

    localparam int RANDOM_ITEMS = 430;
    localparam int SETTLE       = 8;   // extra wait past the pop pipeline

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_req_type;
    logic [ID_W-1:0]       i_reader_id;
    logic [MLEN_W-1:0]     i_msg_length;
    logic [DATA_W-1:0]     i_data_in;
    logic                  i_last_in;
    logic [SLOT_W-1:0]     i_slot_select;
    logic [LIMIT_W-1:0]    i_read_limit;
    logic                  i_unlimited_read;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DATA_W-1:0]     o_data_out;
    logic                  o_last_out;
    logic [STS_W-1:0]      o_status;
    logic [LEN_W-1:0]      o_entry_length;
    logic [FILL_W-1:0]     o_slot_fill;
    logic [SLOT_W-1:0]     o_matched_slot;

    msg_ring_scoreboard sb;
    int unsigned        send_idle_pct;   // chance per cycle that the sender holds off
    int unsigned        out_stall_pct;   // chance per cycle that the receiver stalls
    int unsigned        items_sent;
    int unsigned        item_goal;

    tagged_multi_queue_message_buffer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_reader_id      (i_reader_id),
        .i_msg_length     (i_msg_length),
        .i_data_in        (i_data_in),
        .i_last_in        (i_last_in),
        .i_slot_select    (i_slot_select),
        .i_read_limit     (i_read_limit),
        .i_unlimited_read (i_unlimited_read),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_data_out       (o_data_out),
        .o_last_out       (o_last_out),
        .o_status         (o_status),
        .o_entry_length   (o_entry_length),
        .o_slot_fill      (o_slot_fill),
        .o_matched_slot   (o_matched_slot)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver back-pressure, updated on the falling edge
    always @(negedge i_clk)
        i_out_ready = ($urandom_range(99) >= out_stall_pct);

    // every result taken at a rising edge is checked against the oldest expectation
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(t_result'{data: o_data_out, last: o_last_out, status: o_status,
                                      entry_length: o_entry_length, slot_fill: o_slot_fill,
                                      matched_slot: o_matched_slot});

    // hard stop well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("[tagged_multi_queue_message_buffer] ERROR");
        $finish;
    end

    // all fields random; callers overwrite what matters for the item
    function automatic t_ring_req random_req();
        t_ring_req r;
        r.req_type    = 1'($urandom_range(1));
        r.reader_id   = ID_W'($urandom);
        r.msg_length  = MLEN_W'($urandom);
        r.data        = DATA_W'($urandom);
        r.last        = 1'($urandom_range(1));
        r.slot_select = SLOT_W'($urandom);
        r.read_limit  = LIMIT_W'($urandom);
        r.unlimited   = 1'($urandom_range(1));
        return r;
    endfunction

    // present one item; valid stays up across back-to-back items and drops only in gaps
    task automatic send_req(t_ring_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type       = r.req_type;
        i_reader_id      = r.reader_id;
        i_msg_length     = r.msg_length;
        i_data_in        = r.data;
        i_last_in        = r.last;
        i_slot_select    = r.slot_select;
        i_read_limit     = r.read_limit;
        i_unlimited_read = r.unlimited;
        i_in_valid       = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_request(r);
        items_sent++;
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        sb.write_register(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ids first, then the enable word with junk in the unused upper bits
    task automatic program_slots(t_slot_ids ids, logic [SLOTS-1:0] en);
        int s;
        for (s = 0; s < N_IDREGS; s++)
            cfg_write(CFG_IDX_W'(CFG_ID0 + s), ids[s]);
        cfg_write(CFG_ENABLE, {(CFG_DATA_W - SLOTS)'($urandom), en});
    endtask

    // push n items of one message; id and length only count on the first item,
    // later items carry them mostly unchanged and sometimes as noise
    task automatic send_message(logic [ID_W-1:0] rid, logic [MLEN_W-1:0] mlen, int n,
                                bit close);
        t_ring_req r;
        int        i;
        for (i = 0; i < n; i++) begin
            r = random_req();
            r.req_type = REQ_PUSH;
            if (i == 0 || $urandom_range(3) != 0) begin
                r.reader_id  = rid;
                r.msg_length = mlen;
            end
            case ($urandom_range(7))
                0:       r.data = 8'h00;
                1:       r.data = 8'hFF;
                default: r.data = DATA_W'($urandom);
            endcase
            r.last = close && (i == n - 1);
            send_req(r);
        end
    endtask

    task automatic send_pop(logic [SLOT_W-1:0] slot, logic [LIMIT_W-1:0] limit, bit unlim);
        t_ring_req r;
        r = random_req();
        r.req_type    = REQ_POP;
        r.slot_select = slot;
        r.read_limit  = limit;
        r.unlimited   = unlim;
        send_req(r);
    endtask

    // mostly well-formed messages to configured readers, mixed with pops and noise
    task automatic run_phase(int n);
        int unsigned       start;
        int unsigned       pick;
        int unsigned       base;
        int                count;
        logic [ID_W-1:0]   rid;
        logic [MLEN_W-1:0] mlen;
        start = items_sent;
        while (items_sent - start < n && items_sent < item_goal) begin
            // now and then the sender holds back until everything has drained
            if ($urandom_range(99) < 3)
                wait_idle();
            if ($urandom_range(99) < 45) begin
                send_pop(SLOT_W'($urandom_range(SLOTS - 1)),
                         ($urandom_range(99) < 60) ? LIMIT_W'($urandom_range(70))
                                                   : LIMIT_W'($urandom),
                         1'($urandom_range(1)));
            end else begin
                rid  = ($urandom_range(99) < 85) ? sb.slot_id[$urandom_range(SLOTS - 1)]
                                                 : ID_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 55)
                    mlen = MLEN_W'($urandom_range(8));
                else if (pick < 78)
                    mlen = MLEN_W'($urandom_range(40, 9));
                else if (pick < 88)
                    mlen = MLEN_W'($urandom_range(60, 41));
                else if (pick < 94)
                    mlen = MLEN_W'($urandom_range(63, 61));
                else
                    mlen = MLEN_W'($urandom);
                if (mlen + HDR_LEN > ENTRY_BYTES) begin
                    // oversized: a few items are enough, the rest is skipped anyway
                    count = $urandom_range(3, 1);
                end else begin
                    base = (mlen == 0) ? 1 : mlen;
                    pick = $urandom_range(99);
                    if (pick < 85)
                        count = base;                            // exact length
                    else if (pick < 93)
                        count = $urandom_range(base, 1);         // short message
                    else
                        count = base + $urandom_range(3, 1);     // extra bytes
                end
                send_message(rid, mlen, count, 1'b1);
            end
        end
    endtask

    initial begin
        t_slot_ids ids;
        int        p;
        int        s;
        logic [SLOTS-1:0] en;

        sb               = new();
        send_idle_pct    = 0;
        out_stall_pct    = 0;
        items_sent       = 0;
        item_goal        = 0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_ID0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_req_type       = REQ_PUSH;
        i_reader_id      = '0;
        i_msg_length     = '0;
        i_data_in        = '0;
        i_last_in        = 1'b0;
        i_slot_select    = '0;
        i_read_limit     = '0;
        i_unlimited_read = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // nothing enabled after reset: the push finds no reader, the pop finds nothing
        send_message(16'h0000, 16'd0, 1, 1'b1);
        send_pop(2'd0, 16'd0, 1'b1);
        wait_idle();

        // extreme ids; slot 3 shadows slot 0, so the lower slot must win
        ids = '{16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF};
        program_slots(ids, 4'hF);

        send_message(16'hFFFF, 16'd0, 1, 1'b1);      // empty payload, header only
        send_message(16'h1234, 16'd60, 2, 1'b1);     // short message, largest fitting length
        send_message(16'h1234, 16'd61, 2, 1'b1);     // one byte too long: overflow mark
        send_message(16'h0000, 16'hFFFF, 1, 1'b1);   // largest length: overflow mark
        send_message(16'h0000, 16'd1, 3, 1'b1);      // extra bytes beyond the length
        send_message(16'hABCD, 16'd3, 2, 1'b1);      // no reader with this id
        send_pop(2'd0, 16'd0, 1'b1);                 // unlimited read ignores the limit
        send_pop(2'd1, 16'd5, 1'b0);                 // receiver too small
        send_pop(2'd1, 16'hFFFF, 1'b0);              // overflow-marked entry
        send_pop(2'd2, 16'd0, 1'b1);                 // overflow-marked entry
        send_pop(2'd2, 16'd5, 1'b0);                 // limit equal to the entry length
        send_pop(2'd3, 16'hFFFF, 1'b0);              // shadowed slot stays empty

        // fill slot 0 to the brim, then one more message has to be dropped
        repeat (RING_DEPTH + 1) send_message(16'hFFFF, 16'd0, 1, 1'b1);
        wait_idle();

        // clear the ring under a message half way in: the tail is dropped
        send_message(16'h1234, 16'd4, 2, 1'b0);
        wait_idle();
        cfg_write(CFG_ENABLE, 16'h000F);
        send_message(16'h1234, 16'd4, 2, 1'b1);

        // random phases, each under a new register setting and idling pattern
        item_goal = items_sent + RANDOM_ITEMS;
        for (p = 0; items_sent < item_goal; p++) begin
            wait_idle();
            case (p % 4)
                0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin send_idle_pct = 72; out_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  out_stall_pct = 72; end
                default: begin send_idle_pct = 10; out_stall_pct = 10; end
            endcase
            for (s = 0; s < SLOTS; s++) begin
                case ($urandom_range(5))
                    0:       ids[s] = 16'h0000;
                    1:       ids[s] = 16'hFFFF;
                    2:       ids[s] = (s == 0) ? ID_W'($urandom) : ids[s - 1];
                    default: ids[s] = ID_W'($urandom);
                endcase
            end
            // all slots off once, all on twice, a random mix otherwise
            if (p == 2)
                en = '0;
            else if (p == 1 || p == 5)
                en = '1;
            else
                en = SLOTS'($urandom);
            program_slots(ids, en);
            run_phase((p == 2) ? 20 : 55);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("[tagged_multi_queue_message_buffer] OK");
        else
            $display("[tagged_multi_queue_message_buffer] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tmqmb_pkg.sv
rtl/core/tmqmb_front.sv
rtl/core/tmqmb_queue.sv
rtl/core/tmqmb_back.sv
rtl/core/tagged_multi_queue_message_buffer.sv
tb/testbench.sv
